### rtl/sminpq_pkg.sv
package sminpq_pkg;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PRIO_BITS     = 16;
  localparam int unsigned PAYLOAD_BITS  = 32;
  localparam int unsigned FILL_BITS     = $clog2(DEPTH + 1);
  localparam int unsigned ERR_BITS      = 2;
  localparam int unsigned IN_DATA_BITS  = ((PRIO_BITS + PAYLOAD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = PAYLOAD_BITS + PRIO_BITS + 1 + FILL_BITS + ERR_BITS;
  localparam int unsigned OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic signed [PRIO_BITS-1:0] prio_t;
  typedef logic [PAYLOAD_BITS-1:0]     payload_t;
  typedef logic [FILL_BITS-1:0]        fill_t;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_e;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic push;
    logic pop;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

### rtl/sminpq_dp.sv
module sminpq_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sminpq_pkg::dp_cmd_t    cmd_i,
  input  sminpq_pkg::prio_t      in_prio_i,
  input  sminpq_pkg::payload_t   in_payload_i,
  output sminpq_pkg::dp_status_t status_o,
  output sminpq_pkg::prio_t      head_prio_o,
  output sminpq_pkg::payload_t   head_payload_o,
  output sminpq_pkg::fill_t      fill_o
);

  localparam int unsigned Depth = sminpq_pkg::DEPTH;

  // sorted slot array, slot 0 is the head; occupied slots form a prefix
  sminpq_pkg::prio_t    prio_q [Depth];
  sminpq_pkg::payload_t pay_q  [Depth];
  logic [Depth-1:0]     used_q, used_d;
  logic [Depth-1:0]     le;    // slot holds an entry that stays ahead of the new one
  sminpq_pkg::fill_t    count_q, count_d;

  for (genvar g = 0; g < Depth; g++) begin : g_slot
    sminpq_pkg::prio_t    prio_d;
    sminpq_pkg::payload_t pay_d;
    sminpq_pkg::prio_t    up_prio, dn_prio;
    sminpq_pkg::payload_t up_pay, dn_pay;
    logic                 up_le;

    assign le[g] = used_q[g] && (prio_q[g] <= in_prio_i);

    if (g == 0) begin : g_first
      assign up_le   = 1'b1;
      assign up_prio = in_prio_i;
      assign up_pay  = in_payload_i;
    end else begin : g_mid
      assign up_le   = le[g-1];
      assign up_prio = prio_q[g-1];
      assign up_pay  = pay_q[g-1];
    end

    if (g == Depth - 1) begin : g_last
      assign dn_prio = prio_q[g];
      assign dn_pay  = pay_q[g];
    end else begin : g_inner
      assign dn_prio = prio_q[g+1];
      assign dn_pay  = pay_q[g+1];
    end

    always_comb begin
      prio_d = prio_q[g];
      pay_d  = pay_q[g];
      if (cmd_i.push) begin
        if (!le[g]) begin
          if (up_le) begin
            prio_d = in_prio_i;
            pay_d  = in_payload_i;
          end else begin
            prio_d = up_prio;
            pay_d  = up_pay;
          end
        end
      end else if (cmd_i.pop) begin
        prio_d = dn_prio;
        pay_d  = dn_pay;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.push || cmd_i.pop) begin
        prio_q[g] <= prio_d;
        pay_q[g]  <= pay_d;
      end
    end
  end

  always_comb begin
    used_d  = used_q;
    count_d = count_q;
    if (cmd_i.push) begin
      used_d  = {used_q[Depth-2:0], 1'b1};
      count_d = count_q + sminpq_pkg::fill_t'(1);
    end else if (cmd_i.pop) begin
      used_d  = {1'b0, used_q[Depth-1:1]};
      count_d = count_q - sminpq_pkg::fill_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
    end else begin
      used_q  <= used_d;
      count_q <= count_d;
    end
  end

  assign status_o.full  = used_q[Depth-1];
  assign status_o.empty = !used_q[0];
  assign head_prio_o    = used_q[0] ? prio_q[0] : '0;
  assign head_payload_o = used_q[0] ? pay_q[0] : '0;
  assign fill_o         = count_q;

endmodule

### rtl/sminpq_ctrl.sv
module sminpq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_func_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  sminpq_pkg::dp_status_t status_i,
  output sminpq_pkg::dp_cmd_t    cmd_o,
  output sminpq_pkg::err_e       err_o
);

  sminpq_pkg::state_e state_q, state_d;
  sminpq_pkg::err_e   err_q, err_d;
  logic               accept;

  assign accept = in_valid_i && (state_q == sminpq_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sminpq_pkg::ST_IDLE: if (in_valid_i) state_d = sminpq_pkg::ST_RESP;
      sminpq_pkg::ST_RESP: if (out_ready_i) state_d = sminpq_pkg::ST_IDLE;
      default:             state_d = sminpq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    err_d       = err_q;
    case (state_q)
      sminpq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          err_d = sminpq_pkg::ERR_OK;
          if (in_func_i == sminpq_pkg::FUNC_PUSH) begin
            if (status_i.full) err_d = sminpq_pkg::ERR_PUSH_FULL;
            else               cmd_o.push = 1'b1;
          end else begin
            if (status_i.empty) err_d = sminpq_pkg::ERR_POP_EMPTY;
            else                cmd_o.pop = 1'b1;
          end
        end
      end
      sminpq_pkg::ST_RESP: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sminpq_pkg::ST_IDLE;
      err_q   <= sminpq_pkg::ERR_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

### rtl/stable_min_priority_queue.sv
// Stable min priority queue of up to DEPTH (priority, payload) entries, kept
// sorted by signed priority in a row of slot registers; equal priorities stay
// in arrival order. Each beat on the slave side is one push (tuser = 0) or one
// pop (tuser = 1) and yields exactly one result beat on the master side with
// the head entry, empty flag, fill count and error code after that operation.
// A pop on an empty queue reports error 1 and a push on a full queue reports
// error 2; either leaves the queue unchanged. Every slot compares itself with
// the new priority in parallel, so all slots update together; the control
// sequencer takes one input beat, then holds the result until it is taken,
// and takes no new beat before then. No clearing pass is needed after reset.
module stable_min_priority_queue (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] prio (signed), [47:16] payload
  input  logic [sminpq_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // [0] func: 0 push, 1 pop
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [31:0] head_payload, [47:32] head_prio (signed), [48] is_empty,
  // [53:49] fill, [55:54] err_code
  output logic [sminpq_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

  localparam int unsigned PrioBits = sminpq_pkg::PRIO_BITS;
  localparam int unsigned PayBits  = sminpq_pkg::PAYLOAD_BITS;

  sminpq_pkg::dp_cmd_t    cmd;
  sminpq_pkg::dp_status_t status;
  sminpq_pkg::err_e       err;
  sminpq_pkg::prio_t      head_prio;
  sminpq_pkg::payload_t   head_payload;
  sminpq_pkg::fill_t      fill;

  sminpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd),
    .err_o       (err)
  );

  sminpq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_prio_i      (sminpq_pkg::prio_t'(s_axis_tdata[PrioBits-1:0])),
    .in_payload_i   (s_axis_tdata[PrioBits+PayBits-1:PrioBits]),
    .status_o       (status),
    .head_prio_o    (head_prio),
    .head_payload_o (head_payload),
    .fill_o         (fill)
  );

  // result fields are registered state, stable while the beat waits
  assign m_axis_tdata = sminpq_pkg::OUT_DATA_BITS'({err, fill, status.empty,
                                                    head_prio, head_payload});

  // an accepted beat always produces a result beat next cycle
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no result after accepted beat");

  // fill never exceeds the slot count
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= sminpq_pkg::fill_t'(sminpq_pkg::DEPTH))
    else $error("fill out of range");

  // empty flag agrees with the count
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.empty == (fill == '0))
    else $error("empty flag and fill disagree");

  // a dropped push is reported only when the queue really is full
  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && err == sminpq_pkg::ERR_PUSH_FULL) |->
      (fill == sminpq_pkg::fill_t'(sminpq_pkg::DEPTH)))
    else $error("push-full error with free slots");

endmodule

### verif/tb_stable_min_priority_queue.sv
module tb_stable_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH         = sminpq_pkg::DEPTH;
  localparam int unsigned PRIO_BITS     = sminpq_pkg::PRIO_BITS;
  localparam int unsigned PAYLOAD_BITS  = sminpq_pkg::PAYLOAD_BITS;
  localparam int unsigned FILL_BITS     = sminpq_pkg::FILL_BITS;
  localparam int unsigned ERR_BITS      = sminpq_pkg::ERR_BITS;
  localparam int unsigned IN_DATA_BITS  = sminpq_pkg::IN_DATA_BITS;
  localparam int unsigned OUT_DATA_BITS = sminpq_pkg::OUT_DATA_BITS;

  typedef sminpq_pkg::prio_t    prio_t;
  typedef sminpq_pkg::payload_t payload_t;
  typedef sminpq_pkg::fill_t    fill_t;
  typedef sminpq_pkg::func_e    func_e;
  typedef sminpq_pkg::err_e     err_e;

  // no beat on either side for this many cycles ends the run
  localparam int unsigned IDLE_LIMIT  = 4000;
  // extra cycles after the last result cover a late stray beat
  localparam int unsigned TAIL_CYCLES = 16;

  // result bus layout, lowest field first
  localparam int unsigned HEAD_PRIO_LSB = PAYLOAD_BITS;
  localparam int unsigned EMPTY_BIT     = PAYLOAD_BITS + PRIO_BITS;
  localparam int unsigned FILL_LSB      = EMPTY_BIT + 1;
  localparam int unsigned ERR_LSB       = FILL_LSB + FILL_BITS;

  localparam prio_t PRIO_MIN = {1'b1, {(PRIO_BITS-1){1'b0}}};
  localparam prio_t PRIO_MAX = ~PRIO_MIN;

  // one queued op for the sender; drain marks a hold until all results are back
  typedef struct {
    bit       drain;
    func_e    func;
    prio_t    prio;
    payload_t payload;
  } pq_op_t;

  // queue status reported after each op
  typedef struct {
    payload_t head_payload;
    prio_t    head_prio;
    logic     is_empty;
    fill_t    fill;
    err_e     err;
  } pq_status_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata;   // [15:0] prio, [47:16] payload
  logic                      s_axis_tuser;   // [0] func
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;   // payload, prio, empty, fill, err

  stable_min_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow copy of the sorted slots; slot 0 is the head
  prio_t       shadow_prio [DEPTH];
  payload_t    shadow_payload [DEPTH];
  int unsigned shadow_count;

  pq_op_t     pending_ops[$];      // ops waiting to be sent
  pq_status_t expected_status[$];  // one per accepted op, oldest first

  bit          op_taken;           // set at the edge the current op beat is accepted
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned rx_mode;
  int unsigned rx_left;
  int unsigned idle_cycles;
  int unsigned errors;
  int unsigned n_push, n_pop, n_full_drop, n_empty_pop, n_drain, n_status;
  int unsigned peak_fill;

  // Apply one op to the shadow queue and return the status it leaves behind.
  // Push: insert after every entry of lower or equal priority (stable order),
  // dropped when full. Pop: shift everything up one slot, no-op when empty.
  function automatic pq_status_t apply_op(pq_op_t op);
    pq_status_t  st;
    int unsigned pos;
    int unsigned i;
    st.err = sminpq_pkg::ERR_OK;
    if (op.func == sminpq_pkg::FUNC_PUSH) begin
      if (shadow_count >= DEPTH) begin
        st.err = sminpq_pkg::ERR_PUSH_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= op.prio) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_prio[i]    = shadow_prio[i-1];
          shadow_payload[i] = shadow_payload[i-1];
        end
        shadow_prio[pos]    = op.prio;
        shadow_payload[pos] = op.payload;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        st.err = sminpq_pkg::ERR_POP_EMPTY;
      end else begin
        for (i = 0; i + 1 < shadow_count; i++) begin
          shadow_prio[i]    = shadow_prio[i+1];
          shadow_payload[i] = shadow_payload[i+1];
        end
        shadow_count--;
      end
    end
    if (shadow_count != 0) begin
      st.head_payload = shadow_payload[0];
      st.head_prio    = shadow_prio[0];
      st.is_empty     = 1'b0;
    end else begin
      st.head_payload = '0;
      st.head_prio    = '0;
      st.is_empty     = 1'b1;
    end
    st.fill = fill_t'(shadow_count);
    return st;
  endfunction

  function automatic pq_op_t make_op(func_e f, prio_t p, payload_t d);
    pq_op_t op;
    op.drain   = 1'b0;
    op.func    = f;
    op.prio    = p;
    op.payload = d;
    return op;
  endfunction

  task automatic add_drain();
    pq_op_t op;
    op       = make_op(sminpq_pkg::FUNC_POP, '0, '0);
    op.drain = 1'b1;
    pending_ops.push_back(op);
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // Op driver: changes inputs at the falling edge. Holds a beat until the
  // rising edge accepts it, then sends in bursts with random gaps. A drain
  // marker at the head of the list stalls the sender until every status
  // beat has come back. Also drives the result-side stall pattern.
  always @(negedge clk_i) begin : op_driver
    pq_op_t nxt;
    if (rst_ni) begin
      if (!(s_axis_tvalid && !op_taken)) begin
        op_taken = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0 && pending_ops[0].drain) begin
          s_axis_tvalid <= 1'b0;
          if (expected_status.size() == 0) begin
            pending_ops.delete(0);
            n_drain++;
          end
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.payload, nxt.prio};
          s_axis_tuser  <= nxt.func;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            // about a third of the bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      // result side: windows of always-ready, coin-flip, sparse and rare ready
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 160);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 11) == 0);
        end
      endcase
    end
  end

  // Monitor: at the rising edge, an accepted op beat is predicted from what
  // was on the bus, then an accepted status beat is checked against the
  // oldest prediction. Doing both here keeps them in a fixed order.
  always @(posedge clk_i) begin : status_monitor
    pq_op_t     seen;
    pq_status_t want;
    logic       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        seen.drain   = 1'b0;
        seen.func    = func_e'(s_axis_tuser);
        seen.prio    = prio_t'(s_axis_tdata[PRIO_BITS-1:0]);
        seen.payload = payload_t'(s_axis_tdata[PRIO_BITS +: PAYLOAD_BITS]);
        want = apply_op(seen);
        expected_status.push_back(want);
        op_taken = 1'b1;
        moved    = 1'b1;
        if (seen.func == sminpq_pkg::FUNC_PUSH) n_push++;
        else n_pop++;
        if (want.err == sminpq_pkg::ERR_PUSH_FULL) n_full_drop++;
        if (want.err == sminpq_pkg::ERR_POP_EMPTY) n_empty_pop++;
        if (shadow_count > peak_fill) peak_fill = shadow_count;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        n_status++;
        if (expected_status.size() == 0) begin
          $display("%0t ns: status beat with none expected, expected nothing, got %0h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_status.pop_front();
          check_field("head_payload", want.head_payload,
                      m_axis_tdata[PAYLOAD_BITS-1:0]);
          check_field("head_prio", $unsigned(want.head_prio),
                      m_axis_tdata[HEAD_PRIO_LSB +: PRIO_BITS]);
          check_field("is_empty", want.is_empty, m_axis_tdata[EMPTY_BIT]);
          check_field("fill", want.fill, m_axis_tdata[FILL_LSB +: FILL_BITS]);
          check_field("err_code", want.err, m_axis_tdata[ERR_LSB +: ERR_BITS]);
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles, %0d status beats outstanding",
                 $time, idle_cycles, expected_status.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    pq_op_t      op;
    int unsigned bias;
    int unsigned phase;
    int unsigned k;
    int unsigned push_bias [6];

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    op_taken      = 1'b0;
    gap_left      = 0;
    burst_left    = 1;
    rx_mode       = 0;
    rx_left       = 0;
    shadow_count  = 0;
    foreach (shadow_prio[i]) begin
      shadow_prio[i]    = '0;
      shadow_payload[i] = '0;
    end

    // Directed: pop on empty, priority and payload extremes, ties that must
    // keep arrival order, then pop everything and one pop past empty.
    // Pops carry all-ones fields, which must be ignored.
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_POP, '1, '1));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, '0, '0));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, PRIO_MAX, '1));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, PRIO_MIN, 32'h0000_0000));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, PRIO_MIN, 32'h0000_0001));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, '0, 32'h0000_0002));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, PRIO_MAX, 32'h0000_0003));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, '1, 32'h5555_aaaa));
    pending_ops.push_back(make_op(sminpq_pkg::FUNC_PUSH, prio_t'(1), 32'haaaa_5555));
    for (k = 0; k < 9; k++) pending_ops.push_back(make_op(sminpq_pkg::FUNC_POP, '1, '1));
    add_drain();

    // Random phases: push-heavy ones run into the full queue, pop-heavy ones
    // into the empty one. Priorities mix a narrow band (many ties), the
    // extremes, and the full range.
    push_bias = '{60, 85, 30, 95, 15, 50};
    for (phase = 0; phase < 6; phase++) begin
      bias = push_bias[phase];
      for (k = 0; k < 130; k++) begin
        op.drain   = 1'b0;
        op.func    = ($urandom_range(0, 99) < bias) ? sminpq_pkg::FUNC_PUSH
                                                    : sminpq_pkg::FUNC_POP;
        op.payload = payload_t'($urandom);
        if ($urandom_range(0, 15) == 0) op.payload = ($urandom_range(0, 1) == 1) ? '1 : '0;
        case ($urandom_range(0, 3))
          0: begin
            op.prio = prio_t'(int'($urandom_range(0, 8)) - 4);
          end
          1: begin
            case ($urandom_range(0, 3))
              0: op.prio = PRIO_MIN;
              1: op.prio = PRIO_MAX;
              2: op.prio = PRIO_MIN + prio_t'(1);
              default: op.prio = PRIO_MAX - prio_t'(1);
            endcase
          end
          default: begin
            op.prio = prio_t'($urandom);
          end
        endcase
        pending_ops.push_back(op);
        if ($urandom_range(0, 99) == 0) add_drain();
      end
      add_drain();
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d pushes and %0d pops, %0d status beats checked, peak fill %0d of %0d.",
             n_push, n_pop, n_status, peak_fill, DEPTH);
    $display("Saw %0d dropped pushes on full, %0d pops on empty, %0d full drains; %0d errors.",
             n_full_drop, n_empty_pop, n_drain, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
